/* hdl/searchable_stack_store_core_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the searchable stack store.
// ---------------------------------------------------------------------------
`ifndef SEARCHABLE_STACK_STORE_CORE_MACROS_SVH
`define SEARCHABLE_STACK_STORE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/sss_pkg.sv */
// ---------------------------------------------------------------------------
// sss_pkg
// Types and constants shared by the searchable stack store modules.
// ---------------------------------------------------------------------------
`default_nettype none

package sss_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_VALUE_BITS = 32;
    localparam int REQ_VALUE_BITS = 32;
    localparam int HELD_BITS      = 5;

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_DELETE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN,
        ST_SHIFT
    } state_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

endpackage

`default_nettype wire

/* hdl/sss_mem.sv */
// ---------------------------------------------------------------------------
// sss_mem
// Entry storage: one write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module sss_mem #(
    parameter int DEPTH = sss_pkg::DEF_CAPACITY,
    parameter int WIDTH = sss_pkg::DEF_VALUE_BITS
) (
    input  wire logic                         clk,
    input  wire sss_pkg::mem_ctl_t            ctl,
    input  wire logic [$clog2(DEPTH)-1:0]     waddr,
    input  wire logic [$clog2(DEPTH)-1:0]     raddr,
    input  wire logic signed [WIDTH-1:0]      wdata,
    output logic signed [WIDTH-1:0]           rdata
);

    logic signed [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/searchable_stack_store_core.sv */
// ---------------------------------------------------------------------------
// searchable_stack_store_core
// Bounded LIFO store of signed values with search and delete by value.
// ---------------------------------------------------------------------------
// A request (req_type, req_value) is taken when start is high and busy is
// low. Push puts req_value on top, pop removes the top entry, search looks
// for req_value, and delete removes the topmost matching entry and moves the
// entries above it down by one place. Each transaction produces exactly one
// result: done is high for one cycle with status, found, out_value and
// held_count valid, and the receiver must take it in that cycle; there is no
// way to hold a result back.
// The single read port of the entry memory paces the longer requests: search
// compares one entry per cycle walking down from the top, and delete moves
// one entry per cycle. busy is high from the accepting edge until the done
// cycle for pop, search or delete on a non-empty store; a push, or a request
// on an empty store, never raises busy. A new request may be started in the
// done cycle itself.
// Reset empties the store at once; entry contents are not cleared and are
// never read before being written.
// ---------------------------------------------------------------------------
`default_nettype none

`include "searchable_stack_store_core_macros.svh"

module searchable_stack_store_core #(
    parameter int CAPACITY   = sss_pkg::DEF_CAPACITY,
    parameter int VALUE_BITS = sss_pkg::DEF_VALUE_BITS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [1:0]                            req_type,
    input  wire logic signed [sss_pkg::REQ_VALUE_BITS-1:0] req_value,
    output logic                                       done,
    output logic [1:0]                                 status,
    output logic                                       found,
    output logic signed [sss_pkg::REQ_VALUE_BITS-1:0]  out_value,
    output logic [sss_pkg::HELD_BITS-1:0]              held_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = sss_pkg::REQ_VALUE_BITS;

    sss_pkg::state_t  state_reg, state_next;
    sss_pkg::req_t    kind_reg, kind_next;
    sss_pkg::status_t status_reg, status_next;

    logic signed [VALUE_BITS-1:0] key_reg, key_next;
    logic [CW-1:0]                fill_reg, fill_next;
    logic [AW-1:0]                rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]                cmp_ptr_reg, cmp_ptr_next;
    logic                         cmp_vld_reg, cmp_vld_next;
    logic [CW-1:0]                src_reg, src_next;
    logic [AW-1:0]                wr_addr_reg, wr_addr_next;
    logic                         wr_pend_reg, wr_pend_next;
    logic                         done_reg, done_next;
    logic                         found_reg, found_next;
    logic signed [RW-1:0]         out_value_reg, out_value_next;

    sss_pkg::mem_ctl_t            mem_ctl;
    logic [AW-1:0]                mem_waddr;
    logic [AW-1:0]                mem_raddr;
    logic signed [VALUE_BITS-1:0] mem_wdata;
    logic signed [VALUE_BITS-1:0] rd_data;

    logic signed [VALUE_BITS-1:0] key_in;
    logic [AW-1:0]                top_idx;
    logic                         empty;
    logic                         full;
    logic                         hit;

    sss_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_BITS)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .raddr (mem_raddr),
        .wdata (mem_wdata),
        .rdata (rd_data)
    );

    assign key_in  = VALUE_BITS'(req_value);
    assign top_idx = AW'(fill_reg - CW'(1));
    assign empty   = (fill_reg == '0);
    assign full    = (fill_reg == CW'(CAPACITY));
    // The single compare unit: registered read data against the search key.
    assign hit     = cmp_vld_reg && (rd_data == key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sss_pkg::ST_IDLE;
            fill_reg    <= '0;
            cmp_vld_reg <= 1'b0;
            wr_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            cmp_vld_reg <= cmp_vld_next;
            wr_pend_reg <= wr_pend_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        key_reg       <= key_next;
        rd_ptr_reg    <= rd_ptr_next;
        cmp_ptr_reg   <= cmp_ptr_next;
        src_reg       <= src_next;
        wr_addr_reg   <= wr_addr_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
        out_value_reg <= out_value_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        fill_next      = fill_reg;
        rd_ptr_next    = rd_ptr_reg;
        cmp_ptr_next   = cmp_ptr_reg;
        cmp_vld_next   = cmp_vld_reg;
        src_next       = src_reg;
        wr_addr_next   = wr_addr_reg;
        wr_pend_next   = wr_pend_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        found_next     = found_reg;
        out_value_next = out_value_reg;
        mem_ctl        = '0;
        mem_waddr      = wr_addr_reg;
        mem_raddr      = rd_ptr_reg;
        mem_wdata      = rd_data;

        unique case (state_reg)
            sss_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    kind_next      = sss_pkg::req_t'(req_type);
                    key_next       = key_in;
                    found_next     = 1'b0;
                    out_value_next = '0;
                    status_next    = sss_pkg::STAT_OK;
                    unique case (sss_pkg::req_t'(req_type)) inside
                        sss_pkg::REQ_PUSH:
                        begin
                            done_next = 1'b1;
                            if (full)
                            begin
                                status_next = sss_pkg::STAT_FULL;
                            end
                            else
                            begin
                                mem_ctl.we = 1'b1;
                                mem_waddr  = AW'(fill_reg);
                                mem_wdata  = key_in;
                                fill_next  = fill_reg + CW'(1);
                            end
                        end
                        sss_pkg::REQ_POP:
                        begin
                            if (empty)
                            begin
                                done_next   = 1'b1;
                                status_next = sss_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                mem_ctl.re = 1'b1;
                                mem_raddr  = top_idx;
                                state_next = sss_pkg::ST_POP;
                            end
                        end
                        sss_pkg::REQ_SEARCH, sss_pkg::REQ_DELETE:
                        begin
                            if (empty)
                            begin
                                done_next = 1'b1;
                                if (sss_pkg::req_t'(req_type) == sss_pkg::REQ_SEARCH)
                                begin
                                    status_next = sss_pkg::STAT_NOT_FOUND;
                                end
                                else
                                begin
                                    status_next = sss_pkg::STAT_EMPTY;
                                end
                            end
                            else
                            begin
                                rd_ptr_next  = top_idx;
                                cmp_vld_next = 1'b0;
                                state_next   = sss_pkg::ST_SCAN;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end

            sss_pkg::ST_POP:
            begin
                done_next      = 1'b1;
                out_value_next = RW'(rd_data);
                fill_next      = fill_reg - CW'(1);
                state_next     = sss_pkg::ST_IDLE;
            end

            sss_pkg::ST_SCAN:
            begin
                // Reads run one entry ahead of the compare, walking down.
                if (hit)
                begin
                    cmp_vld_next = 1'b0;
                    found_next   = 1'b1;
                    if (kind_reg == sss_pkg::REQ_SEARCH)
                    begin
                        done_next  = 1'b1;
                        state_next = sss_pkg::ST_IDLE;
                    end
                    else
                    begin
                        out_value_next = RW'(rd_data);
                        src_next       = CW'(cmp_ptr_reg) + CW'(1);
                        wr_pend_next   = 1'b0;
                        state_next     = sss_pkg::ST_SHIFT;
                    end
                end
                else if (cmp_vld_reg && (cmp_ptr_reg == '0))
                begin
                    cmp_vld_next = 1'b0;
                    done_next    = 1'b1;
                    status_next  = sss_pkg::STAT_NOT_FOUND;
                    state_next   = sss_pkg::ST_IDLE;
                end
                else
                begin
                    mem_ctl.re   = 1'b1;
                    mem_raddr    = rd_ptr_reg;
                    cmp_ptr_next = rd_ptr_reg;
                    cmp_vld_next = 1'b1;
                    if (rd_ptr_reg != '0)
                    begin
                        rd_ptr_next = rd_ptr_reg - AW'(1);
                    end
                end
            end

            sss_pkg::ST_SHIFT:
            begin
                // Each entry above the deleted one is read, then written one
                // place lower in the following cycle.
                mem_ctl.we = wr_pend_reg;
                mem_waddr  = wr_addr_reg;
                mem_wdata  = rd_data;
                if (src_reg < fill_reg)
                begin
                    mem_ctl.re   = 1'b1;
                    mem_raddr    = AW'(src_reg);
                    wr_addr_next = AW'(src_reg - CW'(1));
                    wr_pend_next = 1'b1;
                    src_next     = src_reg + CW'(1);
                end
                else
                begin
                    wr_pend_next = 1'b0;
                    done_next    = 1'b1;
                    fill_next    = fill_reg - CW'(1);
                    state_next   = sss_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sss_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg != sss_pkg::ST_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign found      = found_reg;
    assign out_value  = out_value_reg;
    assign held_count = sss_pkg::HELD_BITS'(fill_reg);

    `SSS_ASSERT_SAME(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= CW'(CAPACITY),
                     "fill count above capacity")
    `SSS_ASSERT_NEXT(a_start_progress, clk, rst_n, start && !busy, busy || done,
                     "accepted request neither busy nor done")
    `SSS_ASSERT_SAME(a_fill_on_done, clk, rst_n, fill_reg != $past(fill_reg), done,
                     "fill count changed without a result")
    `SSS_ASSERT_SAME(a_found_ok, clk, rst_n, done && found, status_reg == sss_pkg::STAT_OK,
                     "match reported with failing status")
    `SSS_ASSERT_SAME(a_write_when_working, clk, rst_n, mem_ctl.we, busy || start,
                     "entry write while idle")

endmodule

`default_nettype wire
